// ----- src/rbsh_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbsh_pkg
// Shared constants, types and helpers for the ray/box slab hit test.
// ---------------------------------------------------------------------------
package rbsh_pkg;

  localparam int CELL_W = 16;
  localparam int ORG_W  = 32;
  localparam int DIR_W  = 16;
  localparam int T_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int BLOCK_EDGE_DEF = 65536;

  // numerator is scaled by 2^14 to match the q2.14 direction
  localparam int DIR_FRAC = 14;

  // quotient bits produced by the divider, the rest is caught as overflow
  localparam int QBITS = 33;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES = 1 + (QBITS + DIV_STEPS - 1) / DIV_STEPS;

  localparam int FRONT_STAGES = 4;
  localparam int MERGE_STAGES = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

  localparam logic signed [DIR_W-1:0] DIR_Z_RESET = -16'sd16384;

  localparam logic signed [T_W-1:0] T_SAT_HI     = 32'sh7fff_ffff;
  localparam logic signed [T_W-1:0] T_SAT_LO     = 32'sh8000_0000;
  localparam logic signed [T_W-1:0] T_NEAR_FLOOR = 32'sd1;
  localparam logic signed [T_W-1:0] T_FAR_CEIL   = 32'sd655360000;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [QBITS-1:0] q;
  } div_res_t;

  // signed, saturated t from a magnitude quotient
  function automatic logic signed [T_W-1:0] sat_t(input div_res_t r);
    logic signed [T_W-1:0] v;
    v = '0;
    if (r.ovf) begin
      v = r.neg ? T_SAT_LO : T_SAT_HI;
    end else if (!r.neg) begin
      v = (r.q > QBITS'(T_SAT_HI)) ? T_SAT_HI : T_W'(r.q);
    end else begin
      v = (r.q > (QBITS'(1) << (T_W - 1))) ? T_SAT_LO : T_W'(-r.q);
    end
    return v;
  endfunction

endpackage

// ----- src/rbsh_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbsh_front
// Box bounds, slab distances to the origin and their scaled magnitudes.
// ---------------------------------------------------------------------------
module rbsh_front #(
  parameter int BLOCK_EDGE = rbsh_pkg::BLOCK_EDGE_DEF,
  parameter int MW = 50
) (
  input  logic clk,
  input  logic [rbsh_pkg::FRONT_STAGES-1:0] en,
  input  logic signed [rbsh_pkg::CELL_W-1:0] cell_x,
  input  logic signed [rbsh_pkg::CELL_W-1:0] cell_y,
  input  logic signed [rbsh_pkg::CELL_W-1:0] cell_z,
  input  logic plant_hitbox,
  input  logic [2:0][rbsh_pkg::ORG_W-1:0] origin,
  input  logic [2:0][rbsh_pkg::DIR_W-1:0] dir,
  output logic [2:0][MW-1:0] mag_min,
  output logic [2:0][MW-1:0] mag_max,
  output logic [2:0] neg_min,
  output logic [2:0] neg_max,
  output logic [2:0] in_slab
);

  localparam int EW = $clog2(BLOCK_EDGE) + 2;
  localparam int PW = rbsh_pkg::CELL_W + EW;
  localparam int BW = PW + 1;
  localparam int DW = MW - rbsh_pkg::DIR_FRAC;

  localparam logic signed [PW-1:0] EDGE_P = PW'(BLOCK_EDGE);
  localparam logic signed [BW-1:0] EDGE_B = BW'(BLOCK_EDGE);
  localparam logic signed [BW-1:0] QTR_B  = BW'(BLOCK_EDGE / 4);
  localparam logic signed [BW-1:0] HALF_B = BW'(2 * (BLOCK_EDGE / 4));
  localparam int CELL_W_T = rbsh_pkg::CELL_W;

  logic signed [CELL_W_T-1:0] cells [3];

  logic plant1;

  assign cells[0] = cell_x;
  assign cells[1] = cell_y;
  assign cells[2] = cell_z;

  always_ff @(posedge clk) begin
    if (en[0]) plant1 <= plant_hitbox;
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [PW-1:0] prod;
    logic signed [BW-1:0] bmin, bmax;
    logic signed [DW-1:0] dmin, dmax;
    logic [DW-1:0] amin, amax;

    assign amin = dmin[DW-1] ? DW'(-dmin) : DW'(dmin);
    assign amax = dmax[DW-1] ? DW'(-dmax) : DW'(dmax);

    always_ff @(posedge clk) begin
      if (en[0]) begin
        prod <= PW'(cells[a]) * EDGE_P;
      end
      if (en[1]) begin
        // plant box: quarter edge in on x and z, half edge off the top
        bmin <= BW'(prod) + ((plant1 && a != 1) ? QTR_B : BW'(0));
        bmax <= BW'(prod) + EDGE_B
              - (plant1 ? ((a == 1) ? HALF_B : QTR_B) : BW'(0));
      end
      if (en[2]) begin
        dmin <= DW'(bmin) - DW'($signed(origin[a]));
        dmax <= DW'(bmax) - DW'($signed(origin[a]));
      end
      if (en[3]) begin
        mag_min[a] <= {amin, {rbsh_pkg::DIR_FRAC{1'b0}}};
        mag_max[a] <= {amax, {rbsh_pkg::DIR_FRAC{1'b0}}};
        neg_min[a] <= dmin[DW-1] ^ dir[a][rbsh_pkg::DIR_W-1];
        neg_max[a] <= dmax[DW-1] ^ dir[a][rbsh_pkg::DIR_W-1];
        in_slab[a] <= (dmin[DW-1] || dmin == '0) && !dmax[DW-1];
      end
    end
  end

endmodule

// ----- src/rbsh_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbsh_div
// Pipelined restoring divider, magnitude by |dir|, a few quotient bits a stage.
// ---------------------------------------------------------------------------
module rbsh_div #(
  parameter int MW = 50,
  parameter int SW = 1
) (
  input  logic clk,
  input  logic [rbsh_pkg::DIV_STAGES-1:0] en,
  input  logic [rbsh_pkg::DIR_W-1:0] dir,
  input  logic [MW-1:0] mag,
  input  logic neg,
  input  logic [SW-1:0] side_in,
  output rbsh_pkg::div_res_t res,
  output logic [SW-1:0] side_out
);

  localparam int QB = rbsh_pkg::QBITS;
  localparam int DS = rbsh_pkg::DIV_STAGES;
  localparam int ST = rbsh_pkg::DIV_STEPS;
  localparam int RW = rbsh_pkg::DIR_W + 1;
  localparam int HW = MW - QB;
  localparam int CW = (HW > RW) ? HW : RW;

  logic [RW-1:0] dabs;
  logic [CW-1:0] hi_ext;

  logic [RW-1:0] rem_r [DS];
  logic [QB-1:0] q_r   [DS];
  logic [QB-1:0] n_r   [DS];
  logic          neg_r [DS];
  logic          ovf_r [DS];
  logic [SW-1:0] side_r [DS];

  // one extra bit so the most negative direction has a magnitude
  assign dabs = dir[rbsh_pkg::DIR_W-1] ? RW'(-$signed({dir[rbsh_pkg::DIR_W-1], dir}))
                                       : RW'(dir);
  assign hi_ext = CW'(mag[MW-1:QB]);

  // quotient of 2^QBITS or more saturates anyway
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ovf_r[0]  <= hi_ext >= CW'(dabs);
      rem_r[0]  <= RW'(hi_ext);
      n_r[0]    <= mag[QB-1:0];
      q_r[0]    <= '0;
      neg_r[0]  <= neg;
      side_r[0] <= side_in;
    end
  end

  for (genvar s = 1; s < DS; s++) begin : g_stage
    logic [RW-1:0] rem_c;
    logic [QB-1:0] q_c, n_c;
    logic [RW:0]   tmp;

    always_comb begin
      rem_c = rem_r[s-1];
      q_c   = q_r[s-1];
      n_c   = n_r[s-1];
      tmp   = '0;
      for (int j = 0; j < ST; j++) begin
        if ((s - 1) * ST + j < QB) begin
          tmp = {rem_c, n_c[QB-1]};
          n_c = {n_c[QB-2:0], 1'b0};
          if (tmp >= {1'b0, dabs}) begin
            tmp = tmp - {1'b0, dabs};
            q_c = {q_c[QB-2:0], 1'b1};
          end else begin
            q_c = {q_c[QB-2:0], 1'b0};
          end
          rem_c = tmp[RW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s]  <= rem_c;
        q_r[s]    <= q_c;
        n_r[s]    <= n_c;
        neg_r[s]  <= neg_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign res.neg  = neg_r[DS-1];
  assign res.ovf  = ovf_r[DS-1];
  assign res.q    = q_r[DS-1];
  assign side_out = side_r[DS-1];

endmodule

// ----- src/rbsh_merge.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbsh_merge
// Saturates the slab distances, folds entry and exit, decides the hit.
// ---------------------------------------------------------------------------
module rbsh_merge (
  input  logic clk,
  input  logic [rbsh_pkg::MERGE_STAGES-1:0] en,
  input  rbsh_pkg::div_res_t [2:0] res_min,
  input  rbsh_pkg::div_res_t [2:0] res_max,
  input  logic [2:0] in_slab,
  input  logic [2:0] dir_zero,
  output logic hit
);

  localparam int TW = rbsh_pkg::T_W;

  logic signed [TW-1:0] t0 [3];
  logic signed [TW-1:0] t1 [3];
  logic [2:0] in_slab1;
  logic signed [TW-1:0] tn [3];
  logic signed [TW-1:0] tf [3];
  logic ok2, ok3;
  logic signed [TW-1:0] lo, hi;
  logic signed [TW-1:0] lo_a, lo_b, hi_a, hi_b;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int a = 0; a < 3; a++) begin
        t0[a] <= rbsh_pkg::sat_t(res_min[a]);
        t1[a] <= rbsh_pkg::sat_t(res_max[a]);
      end
      in_slab1 <= in_slab;
    end
    if (en[1]) begin
      for (int a = 0; a < 3; a++) begin
        if (dir_zero[a]) begin
          // parallel ray puts no bound on t
          tn[a] <= rbsh_pkg::T_SAT_LO;
          tf[a] <= rbsh_pkg::T_SAT_HI;
        end else begin
          tn[a] <= (t0[a] < t1[a]) ? t0[a] : t1[a];
          tf[a] <= (t0[a] < t1[a]) ? t1[a] : t0[a];
        end
      end
      ok2 <= &(in_slab1 | ~dir_zero);
    end
    if (en[2]) begin
      lo  <= (lo_a > lo_b) ? lo_a : lo_b;
      hi  <= (hi_a < hi_b) ? hi_a : hi_b;
      ok3 <= ok2;
    end
    if (en[3]) begin
      hit <= ok3 && (lo < hi);
    end
  end

  assign lo_a = (tn[0] > rbsh_pkg::T_NEAR_FLOOR) ? tn[0] : rbsh_pkg::T_NEAR_FLOOR;
  assign lo_b = (tn[1] > tn[2]) ? tn[1] : tn[2];
  assign hi_a = (tf[0] < rbsh_pkg::T_FAR_CEIL) ? tf[0] : rbsh_pkg::T_FAR_CEIL;
  assign hi_b = (tf[1] < tf[2]) ? tf[1] : tf[2];

endmodule

// ----- src/ray_box_slab_hit_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_box_slab_hit_test
// Slab test of a configured ray against one grid cell box per transfer.
// ---------------------------------------------------------------------------
// usage:
//   program origin_x/y/z (q16.16) and dir_x/y/z (q2.14) through the cfg
//   channel (cfg_ready is always high) while no items are in flight.
//   each input transfer (in_valid high, in_stall low) carries one cell and
//   a plant flag; exactly one hit result leaves per item, in order.
// the pipe has 18 stages in all: 4 bound/distance stages, 10 divider
//   stages and 4 compare stages.
// one item per cycle when out_stall is low; six pipelined dividers, one
//   per slab distance, each take one item a cycle while not stalled.
// stall: every stage holds its item while the next one is full and
//   stalled; empty stages still fill, so in_stall rises only once the whole
//   pipe is full behind a stalled output.
// reset: clears all stage valid bits and loads the register defaults
//   (origin 0, direction 0,0,-1).
// ---------------------------------------------------------------------------
module ray_box_slab_hit_test #(
  parameter int BLOCK_EDGE = rbsh_pkg::BLOCK_EDGE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [rbsh_pkg::CELL_W-1:0] cell_x,
  input  logic signed [rbsh_pkg::CELL_W-1:0] cell_y,
  input  logic signed [rbsh_pkg::CELL_W-1:0] cell_z,
  input  logic plant_hitbox,
  output logic out_valid,
  input  logic out_stall,
  output logic hit,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [rbsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbsh_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int EW = $clog2(BLOCK_EDGE) + 2;
  localparam int BW = rbsh_pkg::CELL_W + EW + 1;
  localparam int DW = ((BW > rbsh_pkg::ORG_W) ? BW : rbsh_pkg::ORG_W) + 1;
  localparam int MW = DW + rbsh_pkg::DIR_FRAC;
  localparam int FS = rbsh_pkg::FRONT_STAGES;
  localparam int DS = rbsh_pkg::DIV_STAGES;
  localparam int NS = FS + DS + rbsh_pkg::MERGE_STAGES;

  logic [2:0][rbsh_pkg::ORG_W-1:0] origin;
  logic [2:0][rbsh_pkg::DIR_W-1:0] dir;
  logic [2:0] dir_zero;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  logic [2:0][MW-1:0] mag_min, mag_max;
  logic [2:0] neg_min, neg_max, in_slab_f, in_slab_d;
  rbsh_pkg::div_res_t [2:0] res_min, res_max;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
      dir[0] <= '0;
      dir[1] <= '0;
      dir[2] <= rbsh_pkg::DIR_Z_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rbsh_pkg::REG_ORIGIN_X: origin[0] <= cfg_data;
        rbsh_pkg::REG_ORIGIN_Y: origin[1] <= cfg_data;
        rbsh_pkg::REG_ORIGIN_Z: origin[2] <= cfg_data;
        rbsh_pkg::REG_DIR_X:    dir[0] <= cfg_data[rbsh_pkg::DIR_W-1:0];
        rbsh_pkg::REG_DIR_Y:    dir[1] <= cfg_data[rbsh_pkg::DIR_W-1:0];
        rbsh_pkg::REG_DIR_Z:    dir[2] <= cfg_data[rbsh_pkg::DIR_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_dz
    assign dir_zero[a] = (dir[a] == '0);
  end

  // a stage takes new data when it is empty or its successor moves on
  always_comb begin
    rdy[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[NS-1];

  rbsh_front #(.BLOCK_EDGE(BLOCK_EDGE), .MW(MW)) u_front (
    .clk          (clk),
    .en           (rdy[FS-1:0]),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .cell_z       (cell_z),
    .plant_hitbox (plant_hitbox),
    .origin       (origin),
    .dir          (dir),
    .mag_min      (mag_min),
    .mag_max      (mag_max),
    .neg_min      (neg_min),
    .neg_max      (neg_max),
    .in_slab      (in_slab_f)
  );

  for (genvar a = 0; a < 3; a++) begin : g_div
    logic unused_side;

    rbsh_div #(.MW(MW), .SW(1)) u_div_min (
      .clk      (clk),
      .en       (rdy[FS+DS-1:FS]),
      .dir      (dir[a]),
      .mag      (mag_min[a]),
      .neg      (neg_min[a]),
      .side_in  (in_slab_f[a]),
      .res      (res_min[a]),
      .side_out (in_slab_d[a])
    );

    rbsh_div #(.MW(MW), .SW(1)) u_div_max (
      .clk      (clk),
      .en       (rdy[FS+DS-1:FS]),
      .dir      (dir[a]),
      .mag      (mag_max[a]),
      .neg      (neg_max[a]),
      .side_in  (in_slab_f[a]),
      .res      (res_max[a]),
      .side_out (unused_side)
    );
  end

  rbsh_merge u_merge (
    .clk      (clk),
    .en       (rdy[NS-1:FS+DS]),
    .res_min  (res_min),
    .res_max  (res_max),
    .in_slab  (in_slab_d),
    .dir_zero (dir_zero),
    .hit      (hit)
  );

endmodule
